[rtl/assert_macros.svh]
// Assertion macros used by the checker of the texture scaler.
// No dependencies; every macro samples on clk, and all but ASSERT_NEXT_ALL refer to rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle, outside reset.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent holds in the next cycle, outside reset.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// The consequent holds in the next cycle, reset included.
`define ASSERT_NEXT_ALL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/tsp_pkg.sv]
// Shared constants, command and register codes for the texture scaler.
// Has no dependencies; used by the top level and the checker.
package tsp_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int TEXEL_W = 32;
  localparam int SIZE_W  = 9;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_S     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_T     = 3'd5;

  typedef logic [SIZE_W-1:0] size_t;

endpackage

[rtl/texture_scale_pad_unit.sv]
// Load: one word per cycle while idle, written to the RAM in the cycle accepted.
// Emit: the 17-step restoring divider runs, then the read address is registered,
// the RAM is read and the word is loaded into the output register; then idle.
// The output register lets loads continue while a result waits to be taken.
// Synchronous active-low reset clears positions, registers and handshake state;
// the texel RAM is not cleared.
module texture_scale_pad_unit import tsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TEXEL_W-1:0]   in_tdata,   // [31:0] texel
  input  logic                 in_tuser,   // [0] cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TEXEL_W-1:0]   out_tdata,  // [31:0] pixel
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam int NUM_W = COL_W + SIZE_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  function automatic size_t eff_size(input size_t v, input size_t mx);
    size_t r;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] pick_index(input logic [NUM_W-1:0] q,
                                                   input logic [COL_W-1:0] dest,
                                                   input size_t s, input logic scale);
    logic [NUM_W-1:0] idx;
    logic [NUM_W-1:0] lim;
    idx = scale ? q : NUM_W'(dest);
    lim = NUM_W'(s - size_t'(1));
    if (idx > lim) begin
      idx = lim;
    end
    return idx[COL_W-1:0];
  endfunction

  logic [2:0]         state_r, state_nxt;
  size_t              src_w_r, src_h_r, surf_w_r, surf_h_r;
  logic               scale_s_r, scale_t_r;
  logic [COL_W-1:0]   load_col_r, emit_col_r, dcol_r;
  logic [ROW_W-1:0]   load_row_r, emit_row_r, drow_r;
  logic [NUM_W-1:0]   num_x_r, num_y_r;
  size_t              rem_x_r, rem_y_r;
  logic [CNT_W-1:0]   div_cnt_r;
  logic               last_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               out_tvalid_r;
  logic [TEXEL_W-1:0] out_tdata_r;
  logic               out_tlast_r;

  size_t              sw, sh, dw, dh;
  logic               in_acc, load_acc, emit_acc, out_load;
  logic               col_wrap_l, row_wrap_l, col_wrap_e, row_wrap_e;
  logic [SIZE_W:0]    rsh_x, rsh_y;
  logic               ge_x, ge_y;
  logic [TEXEL_W-1:0] ram_rdata;

  assign sw = eff_size(src_w_r,  size_t'(MAX_WIDTH));
  assign sh = eff_size(src_h_r,  size_t'(MAX_HEIGHT));
  assign dw = eff_size(surf_w_r, size_t'(MAX_WIDTH));
  assign dh = eff_size(surf_h_r, size_t'(MAX_HEIGHT));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser == CMD_LOAD);
  assign emit_acc  = in_acc && (in_tuser == CMD_EMIT);
  assign out_load  = (state_r == ST_HOLD) && (!out_tvalid_r || out_tready);

  assign col_wrap_l = (size_t'(load_col_r) + size_t'(1)) >= sw;
  assign row_wrap_l = (size_t'(load_row_r) + size_t'(1)) >= sh;
  assign col_wrap_e = (size_t'(emit_col_r) + size_t'(1)) >= dw;
  assign row_wrap_e = (size_t'(emit_row_r) + size_t'(1)) >= dh;

  assign rsh_x = {rem_x_r, num_x_r[NUM_W-1]};
  assign rsh_y = {rem_y_r, num_y_r[NUM_W-1]};
  assign ge_x  = rsh_x >= {1'b0, dw};
  assign ge_y  = rsh_y >= {1'b0, dh};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (emit_acc) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_w_r      <= size_t'(1);
      src_h_r      <= size_t'(1);
      surf_w_r     <= size_t'(1);
      surf_h_r     <= size_t'(1);
      scale_s_r    <= 1'b0;
      scale_t_r    <= 1'b0;
      load_col_r   <= '0;
      load_row_r   <= '0;
      emit_col_r   <= '0;
      emit_row_r   <= '0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:   src_w_r   <= cfg_wdata;
          REG_SRC_HEIGHT:  src_h_r   <= cfg_wdata;
          REG_SURF_WIDTH:  surf_w_r  <= cfg_wdata;
          REG_SURF_HEIGHT: surf_h_r  <= cfg_wdata;
          REG_SCALE_S:     scale_s_r <= cfg_wdata[0];
          REG_SCALE_T:     scale_t_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (load_acc) begin
        if (col_wrap_l) begin
          load_col_r <= '0;
          load_row_r <= row_wrap_l ? '0 : load_row_r + ROW_W'(1);
        end else begin
          load_col_r <= load_col_r + COL_W'(1);
        end
      end

      if (emit_acc) begin
        div_cnt_r <= '0;
        if (col_wrap_e) begin
          emit_col_r <= '0;
          emit_row_r <= row_wrap_e ? '0 : emit_row_r + ROW_W'(1);
        end else begin
          emit_col_r <= emit_col_r + COL_W'(1);
        end
      end else if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + CNT_W'(1);
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      dcol_r  <= emit_col_r;
      drow_r  <= emit_row_r;
      last_r  <= col_wrap_e && row_wrap_e;
      num_x_r <= NUM_W'(emit_col_r * sw);
      num_y_r <= NUM_W'(emit_row_r * sh);
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (state_r == ST_DIV) begin
      num_x_r <= {num_x_r[NUM_W-2:0], ge_x};
      num_y_r <= {num_y_r[NUM_W-2:0], ge_y};
      rem_x_r <= ge_x ? SIZE_W'(rsh_x - {1'b0, dw}) : rsh_x[SIZE_W-1:0];
      rem_y_r <= ge_y ? SIZE_W'(rsh_y - {1'b0, dh}) : rsh_y[SIZE_W-1:0];
    end
    if (state_r == ST_ADDR) begin
      addr_r <= {pick_index(num_y_r, drow_r, sh, scale_t_r),
                 pick_index(num_x_r, dcol_r, sw, scale_s_r)};
    end
    if (out_load) begin
      out_tdata_r <= ram_rdata;
      out_tlast_r <= last_r;
    end
  end

  tsp_ram #(
    .WIDTH(TEXEL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (load_acc),
    .waddr({load_row_r, load_col_r}),
    .wdata(in_tdata),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

[rtl/tsp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tsp_checker.sv]
// Port-level checks for the texture scaler, bound to the top level.
// Depends on tsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsp_checker import tsp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [TEXEL_W-1:0]   out_tdata,
  input logic                 out_tlast
);

  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `ASSERT_NEXT_ALL(a_rst_clears, !rst_n, !out_tvalid && in_tready)
  `ASSERT_NEXT(a_emit_busy, in_tvalid && in_tready && (in_tuser == CMD_EMIT), !in_tready)
  `ASSERT_NEXT(a_load_free, in_tvalid && in_tready && (in_tuser == CMD_LOAD), in_tready)
  `ASSERT_SAME(a_ready_idle, in_tready && !$past(in_tready) && rst_n && $past(rst_n), $past(out_tvalid) || out_tvalid)

endmodule

bind texture_scale_pad_unit tsp_checker u_tsp_checker (.*);
